FILE: hw/rtl/jch_pkg.sv
// jch_pkg: shared constants and controller/datapath interface types
// for the jump consistent hash block. No dependencies.
`default_nettype none

package jch_pkg;

	localparam int KEY_W  = 64;
	localparam int BCNT_W = 32;
	localparam int BKT_W  = 32;
	localparam int HALF_W = 32;

	// LCG multiplier 2862933555777941757, split in halves for the 32x32 unit
	localparam logic [HALF_W-1:0] LCG_MULT_LO = 32'h87B0B0FD;
	localparam logic [HALF_W-1:0] LCG_MULT_HI = 32'h27BB2EE6;

	// quotient bits produced by the divider (jump below 2^32)
	localparam int DIV_STEPS = 32;
	localparam int CNT_W     = 5;

	typedef struct packed {
		logic load;      // take a new word, start the jump chain
		logic mul0;      // key_lo * mult_lo
		logic mul1;      // key_hi * mult_lo
		logic mul2;      // key_lo * mult_hi
		logic madd;      // fold partial products, +1
		logic prep;      // set up divisor and partial remainder
		logic div_step;  // one restoring-division bit
		logic advance;   // candidate takes the new jump
		logic emit;      // candidate into output register
	} cmd_t;

	typedef struct packed {
		logic more;      // jump below bucket count
	} sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/jump_consistent_hash.sv
// Jump consistent hash: key and bucket count in, bucket index out.
// A zero bucket count goes from the check straight to the result; else each jump
// runs the key LCG on one shared 32x32 multiplier (MUL0, MUL1, MUL2, MADD), a
// divider setup, 32 divider bits and a check; the jump count is about ln(bucket_count)+1.
// One word in flight at a time; a new word is taken while the previous result waits.
// Reset (arst_n, async, active low) clears the sequencer and the output valid.
`default_nettype none

module jump_consistent_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // [63:0] key, [95:64] bucket_count
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // [31:0] bucket
);

	jch_pkg::cmd_t cmd;
	jch_pkg::sts_t sts;

	jch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	jch_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.key          (s_tdata[63:0]),
		.bucket_count (s_tdata[95:64]),
		.sts          (sts),
		.bucket       (m_tdata)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/jch_dp.sv
// jch_dp: datapath of the jump consistent hash block: key LCG over a shared
// 32x32 multiplier, restoring divider for the jump, candidate and result regs.
// Depends on jch_pkg.
`default_nettype none

module jch_dp (
	input  wire logic                         clk,
	input  wire jch_pkg::cmd_t                cmd,
	input  wire logic [jch_pkg::KEY_W-1:0]    key,
	input  wire logic [jch_pkg::BCNT_W-1:0]   bucket_count,
	output jch_pkg::sts_t                     sts,
	output logic [jch_pkg::BKT_W-1:0]         bucket
);

	localparam int HW = jch_pkg::HALF_W;

	logic [jch_pkg::KEY_W-1:0]  k_q;
	logic [jch_pkg::KEY_W-1:0]  acc_q;
	logic [2*HW-1:0]            prod_q;
	logic [jch_pkg::BCNT_W-1:0] bcnt_q;
	logic [jch_pkg::BKT_W-1:0]  cand_q;
	logic [HW-1:0]              den_q;
	logic [HW-1:0]              rem_q;
	logic [HW-1:0]              quo_q;
	logic                       ovf_q;
	logic [jch_pkg::BKT_W-1:0]  bucket_q;

	logic [HW-1:0]   mul_a;
	logic [HW-1:0]   mul_b;
	logic [2*HW-1:0] mul_p;
	logic [HW-1:0]   den_w;
	logic [HW:0]     num1_w;
	logic [HW:0]     rem2_w;
	logic [HW:0]     diff_w;
	logic            ge_w;

	always_comb begin
		mul_a = k_q[HW-1:0];
		mul_b = jch_pkg::LCG_MULT_LO;
		if (cmd.mul1) begin
			mul_a = k_q[2*HW-1:HW];
		end
		if (cmd.mul2) begin
			mul_b = jch_pkg::LCG_MULT_HI;
		end
	end

	assign mul_p = mul_a * mul_b;

	// divisor (k >> 33) + 1 is at most 2^31, fits 32 bits
	assign den_w  = {1'b0, k_q[jch_pkg::KEY_W-1:33]} + 32'd1;
	assign num1_w = {1'b0, cand_q} + 33'd1;

	assign rem2_w = {rem_q, quo_q[HW-1]};
	assign diff_w = rem2_w - {1'b0, den_q};
	assign ge_w   = !diff_w[HW];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q    <= key;
			bcnt_q <= bucket_count;
			cand_q <= '1;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
		end
		if (cmd.mul0) begin
			prod_q <= mul_p;
		end
		if (cmd.mul1) begin
			acc_q  <= prod_q;
			prod_q <= mul_p;
		end
		if (cmd.mul2) begin
			acc_q[2*HW-1:HW] <= acc_q[2*HW-1:HW] + prod_q[HW-1:0];
			prod_q           <= mul_p;
		end
		if (cmd.madd) begin
			k_q <= acc_q + {prod_q[HW-1:0], {HW{1'b0}}} + 64'd1;
		end
		if (cmd.prep) begin
			// quotient >= 2^32 exactly when (b+1) >= 2*den; otherwise the top
			// 32 dividend bits reduce to (b+1)>>1, already below den
			den_q <= den_w;
			ovf_q <= num1_w >= {den_w, 1'b0};
			rem_q <= num1_w[HW:1];
			quo_q <= {num1_w[0], {(HW-1){1'b0}}};
		end
		if (cmd.div_step) begin
			rem_q <= ge_w ? diff_w[HW-1:0] : rem2_w[HW-1:0];
			quo_q <= {quo_q[HW-2:0], ge_w};
		end
		if (cmd.advance) begin
			cand_q <= quo_q;
		end
		if (cmd.emit) begin
			bucket_q <= cand_q;
		end
	end

	assign sts.more = !ovf_q && (quo_q < bcnt_q);
	assign bucket   = bucket_q;

endmodule

`default_nettype wire

FILE: hw/rtl/jch_ctrl.sv
// jch_ctrl: sequencer for the jump consistent hash block; steps the datapath
// through multiply, divide and check per jump, owns both handshakes.
// Depends on jch_pkg.
`default_nettype none

module jch_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	input  wire jch_pkg::sts_t sts,
	output jch_pkg::cmd_t      cmd
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MUL0  = 9'b000000010,
		ST_MUL1  = 9'b000000100,
		ST_MUL2  = 9'b000001000,
		ST_MADD  = 9'b000010000,
		ST_PREP  = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_CHECK = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t                    state_q;
	state_t                    state_d;
	logic [jch_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      out_free;

	localparam logic [jch_pkg::CNT_W-1:0] CNT_LAST = jch_pkg::CNT_W'(jch_pkg::DIV_STEPS - 1);

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d  = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_MADD;
			end
			ST_MADD: begin
				cmd.madd = 1'b1;
				state_d  = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.more) begin
					cmd.advance = 1'b1;
					state_d     = ST_MUL0;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.prep) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || m_tready))
		else $error("result overwrote an untaken word");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_LAST) |=> (state_q == ST_CHECK))
		else $error("divider did not finish after its last bit");

	a_prep_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |=> (state_q == ST_DIV && cnt_q == '0))
		else $error("divider count not cleared");

	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && !sts.more) |=> (state_q == ST_DONE))
		else $error("chain did not stop when jump reached bucket count");
`endif

endmodule

`default_nettype wire

FILE: test/jch_checker.sv
// Checker for jump_consistent_hash: watches both stream channels, predicts each bucket
// and compares results in order. Depends on jch_pkg.

module jch_checker (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	input  logic                                      s_tready,
	input  logic [jch_pkg::KEY_W+jch_pkg::BCNT_W-1:0] s_tdata,  // [63:0] key, [95:64] bucket_count
	input  logic                                      m_tvalid,
	input  logic                                      m_tready,
	input  logic [jch_pkg::BKT_W-1:0]                 m_tdata,  // [31:0] bucket
	output int                                        errors,
	output int                                        outstanding,
	output int                                        checked
);

	localparam int KW = jch_pkg::KEY_W;
	localparam int BW = jch_pkg::BCNT_W;
	localparam int RW = jch_pkg::BKT_W;
	localparam logic [KW-1:0] LCG_MULT = {jch_pkg::LCG_MULT_HI, jch_pkg::LCG_MULT_LO};

	logic [RW-1:0] pending_buckets[$];
	int            mismatches = 0;
	int            results_seen = 0;
	int            queued = 0;

	assign errors      = mismatches;
	assign checked     = results_seen;
	assign outstanding = queued;

	// walk the jump chain; candidate starts at -1 so a zero count returns all ones
	function automatic logic [RW-1:0] jump_bucket(input logic [KW-1:0] key,
		input logic [BW-1:0] buckets);
		logic [63:0] cand;
		logic [63:0] jump;
		logic [63:0] k;
		logic [63:0] num;
		logic [63:0] den;
		cand = 64'hFFFF_FFFF;
		jump = '0;
		k    = key;
		while (jump < {32'b0, buckets}) begin
			cand = jump;
			k    = k * LCG_MULT + 64'd1;
			num  = (cand + 64'd1) << 31;
			den  = (k >> 33) + 64'd1;
			jump = num / den;
		end
		return cand[RW-1:0];
	endfunction

	task automatic report(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		logic [RW-1:0] want;
		if (arst_n) begin
			// pop before push: a word cannot leave in the cycle it arrives
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_buckets.size() == 0) begin
					report($sformatf("bucket %0d with no word outstanding", $signed(m_tdata)));
				end else begin
					want = pending_buckets.pop_front();
					if (m_tdata !== want)
						report($sformatf("bucket got %0d (%h), want %0d (%h)",
							$signed(m_tdata), m_tdata, $signed(want), want));
				end
			end
			if (s_tvalid && s_tready)
				pending_buckets.push_back(jump_bucket(s_tdata[KW-1:0],
					s_tdata[KW+BW-1:KW]));
			queued <= pending_buckets.size();
		end
	end

endmodule

FILE: test/jump_consistent_hash_test.sv
// Testbench top for jump_consistent_hash: drives keys and bucket counts with random
// gaps and stalls, checker jch_checker compares. Depends on jch_pkg and the block.

module jump_consistent_hash_test;

	localparam int NUM_RANDOM = 1700;
	localparam int KW = jch_pkg::KEY_W;
	localparam int BW = jch_pkg::BCNT_W;
	localparam int RW = jch_pkg::BKT_W;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [KW+BW-1:0] s_tdata;   // [63:0] key, [95:64] bucket_count
	logic             m_tvalid;
	logic             m_tready;
	logic [RW-1:0]    m_tdata;   // [31:0] bucket

	int errors;
	int outstanding;
	int checked;
	int words_sent;
	int zero_counts;
	int wide_counts;
	bit send_quiet;

	jump_consistent_hash i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	jch_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("timeout with %0d words outstanding", outstanding);
		$display("simulation failed");
		$finish;
	end

	// offer one word, hold it until taken; tvalid stays high for back-to-back words
	task automatic send_word(input logic [KW-1:0] key, input logic [BW-1:0] bcnt);
		int gap;
		if (words_sent % 50 == 0)
			send_quiet = ($urandom_range(0, 3) == 0);
		gap = send_quiet ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {bcnt, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
		if (bcnt == '0)
			zero_counts++;
		if (bcnt[31])
			wide_counts++;
	endtask

	function automatic logic [KW-1:0] random_key();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// log-spread counts keep the jump chains mostly short
	function automatic logic [BW-1:0] random_count();
		int r;
		int w;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 8)
			return 32'h8000_0000;
		if (r < 11)
			return 32'd1;
		w = $urandom_range(1, 31);
		return $urandom & ((32'd1 << w) - 32'd1);
	endfunction

	// receiver: random stalls, quiet stretches, one long hold-off to back up the block
	initial begin
		int gap;
		int got;
		bit quiet;
		got   = 0;
		quiet = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (got % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			gap = quiet ? 0 : $urandom_range(0, 6);
			if (got == 300)
				gap = 2500;
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got++;
		end
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		words_sent  = 0;
		zero_counts = 0;
		wide_counts = 0;
		send_quiet  = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero count, single bucket, full range, counts above 2^31
		send_word('0, '0);
		send_word('1, '0);
		send_word('0, 32'd1);
		send_word('1, 32'd1);
		send_word('0, 32'h8000_0000);
		send_word('1, 32'h8000_0000);
		send_word(64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
		send_word({$urandom, $urandom}, 32'hFFFF_FFFF);
		send_word({$urandom, $urandom}, 32'h8000_0001);
		send_word(64'd1, 32'h7FFF_FFFF);
		send_word({$urandom, $urandom}, 32'd2);
		send_word({$urandom, $urandom}, 32'd3);
		send_word({$urandom, $urandom}, 32'd1000);
		send_word(64'h8000_0000_0000_0000, 32'd65536);

		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == NUM_RANDOM / 2) begin
				// drain completely before carrying on
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
			send_word(random_key(), random_count());
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (2000) @(posedge clk);

		$display("%0d words hashed (%0d zero counts, %0d counts at or above 2^31),",
			words_sent, zero_counts, wide_counts);
		$display("%0d buckets checked; traffic included random gaps, a long output hold-off",
			checked);
		$display("and a full drain pause");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", errors);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/jch_pkg.sv
hw/rtl/jch_dp.sv
hw/rtl/jch_ctrl.sv
hw/rtl/jump_consistent_hash.sv
test/jch_checker.sv
test/jump_consistent_hash_test.sv
